FILE: rtl/second_order_iir_sample_filter_assert.svh
// Assertion macros for the second-order IIR sample filter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SECOND_ORDER_IIR_SAMPLE_FILTER_ASSERT_SVH
`define SECOND_ORDER_IIR_SAMPLE_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is active
`define SOIIR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds across reset
`define SOIIR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SOIIR_ASSERT(label, clk, rst_n, prop, msg)
`define SOIIR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/soiir_pkg.sv
// Package for the second-order IIR sample filter: register indexes,
// coefficient format and the configuration bundle. No dependencies.
package soiir_pkg;

    // Coefficient format: signed Q3.F, fixed 20-bit word
    localparam int COEF_BITS          = 20;
    localparam int CFG_IDX_BITS       = 3;
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 16;

    // Register indexes on the write port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BYPASS    = 3'd0,
        CFG_COEF_IN0  = 3'd1,
        CFG_COEF_IN1  = 3'd2,
        CFG_COEF_IN2  = 3'd3,
        CFG_COEF_OUT1 = 3'd4,
        CFG_COEF_OUT2 = 3'd5
    } t_cfg_idx;

    // Settings seen by the datapath
    typedef struct packed {
        logic                        bypass;
        logic signed [COEF_BITS-1:0] coef_in0;
        logic signed [COEF_BITS-1:0] coef_in1;
        logic signed [COEF_BITS-1:0] coef_in2;
        logic signed [COEF_BITS-1:0] coef_out1;
        logic signed [COEF_BITS-1:0] coef_out2;
    } t_cfg;

endpackage

FILE: rtl/soiir_cfg.sv
// Configuration register file: bypass flag and five filter coefficients.
// Depends on soiir_pkg for register indexes and the t_cfg bundle.
module soiir_cfg
    import soiir_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_addr,
    input  logic [COEF_BITS-1:0]    i_cfg_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode a write; indexes past the list are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_BYPASS:    n_cfg.bypass    = i_cfg_data[0];
                CFG_COEF_IN0:  n_cfg.coef_in0  = i_cfg_data;
                CFG_COEF_IN1:  n_cfg.coef_in1  = i_cfg_data;
                CFG_COEF_IN2:  n_cfg.coef_in2  = i_cfg_data;
                CFG_COEF_OUT1: n_cfg.coef_out1 = i_cfg_data;
                CFG_COEF_OUT2: n_cfg.coef_out2 = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    // Hold settings; reset to pass-through with zero coefficients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bypass    <= 1'b1;
            r_cfg.coef_in0  <= '0;
            r_cfg.coef_in1  <= '0;
            r_cfg.coef_in2  <= '0;
            r_cfg.coef_out1 <= '0;
            r_cfg.coef_out2 <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/soiir_core.sv
// Biquad datapath: history registers, five products, rounding and clamp.
// Depends on soiir_pkg for the coefficient format and t_cfg bundle.
module soiir_core
    import soiir_pkg::*;
#(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_record_start,
    input  logic                          i_advance,
    output logic signed [SAMPLE_BITS-1:0] o_filtered,
    output logic                          o_clipped
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

    logic signed [SAMPLE_BITS-1:0] r_past_in1, r_past_in2, r_past_out1, r_past_out2;
    logic signed [SAMPLE_BITS-1:0] w_x1, w_y1, w_y2;
    logic signed [PROD_W-1:0]      w_p0, w_p1, w_p2, w_p3, w_p4;
    logic signed [PROD_W-1:0]      w_p2_full;
    logic signed [ACC_W-1:0]       w_acc, w_y_full;
    logic signed [SAMPLE_BITS-1:0] w_y;
    logic                          w_clip;

    // Restart history on the first sample of a record
    assign w_x1 = i_record_start ? i_sample : r_past_in1;
    assign w_y1 = i_record_start ? '0 : r_past_out1;
    assign w_y2 = i_record_start ? '0 : r_past_out2;

    // Five products in parallel; the two-back input term drops on a restart
    assign w_p0      = i_cfg.coef_in0  * i_sample;
    assign w_p1      = i_cfg.coef_in1  * w_x1;
    assign w_p2_full = i_cfg.coef_in2  * r_past_in2;
    assign w_p2      = i_record_start ? '0 : w_p2_full;
    assign w_p3      = i_cfg.coef_out1 * w_y1;
    assign w_p4      = i_cfg.coef_out2 * w_y2;

    // Sum, add half an LSB, floor shift
    assign w_acc = ACC_W'(w_p0) + ACC_W'(w_p1) + ACC_W'(w_p2) + ACC_W'(w_p3)
                 + ACC_W'(w_p4) + HALF;
    assign w_y_full = w_acc >>> COEF_FRAC_BITS;

    // Clamp to sample range
    always_comb begin
        w_clip = 1'b1;
        if (w_y_full > SMAX) begin
            w_y = SMAX[SAMPLE_BITS-1:0];
        end else if (w_y_full < SMIN) begin
            w_y = SMIN[SAMPLE_BITS-1:0];
        end else begin
            w_y    = w_y_full[SAMPLE_BITS-1:0];
            w_clip = 1'b0;
        end
    end

    // Pass the sample straight through in bypass
    assign o_filtered = i_cfg.bypass ? i_sample : w_y;
    assign o_clipped  = !i_cfg.bypass && w_clip;

    // Advance history per filtered item; bypass leaves it alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_past_in1  <= '0;
            r_past_in2  <= '0;
            r_past_out1 <= '0;
            r_past_out2 <= '0;
        end else if (i_advance && !i_cfg.bypass) begin
            r_past_in2  <= w_x1;
            r_past_in1  <= i_sample;
            r_past_out2 <= w_y1;
            r_past_out1 <= w_y;
        end
    end

endmodule

FILE: rtl/second_order_iir_sample_filter.sv
// Top level of the second-order IIR sample filter: input and result registers
// with valid/ready control. Depends on soiir_pkg, soiir_cfg, soiir_core.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_sample, i_record_start
//   result    out        o_valid / i_ready   o_filtered, o_clipped
//   config    in         i_cfg_we            i_cfg_addr, i_cfg_data
//
// One item per cycle sustained while i_ready holds; an accepted input passes
// through the input and result registers. The output feedback through the
// five multipliers, adder and clamp is combinational; that path sets the clock.
// Synchronous active-low reset clears control, history and settings.
// A stalled result holds in the output register while the input register
// still takes one more item.
`include "second_order_iir_sample_filter_assert.svh"

module second_order_iir_sample_filter
    import soiir_pkg::*;
#(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_record_start,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_filtered,
    output logic                          o_clipped,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_addr,
    input  logic [COEF_BITS-1:0]          i_cfg_data
);

    t_cfg                          w_cfg;
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_record_start;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filtered;
    logic                          r_clipped;
    logic signed [SAMPLE_BITS-1:0] w_filtered;
    logic                          w_clipped;
    logic                          w_in_fire;
    logic                          w_step;

    soiir_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    soiir_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_sample       (r_sample),
        .i_record_start (r_record_start),
        .i_advance      (w_step),
        .o_filtered     (w_filtered),
        .o_clipped      (w_clipped)
    );

    // Move an item to the result register when it is empty or draining
    assign w_step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_step;
    assign w_in_fire = i_valid && o_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_sample       <= i_sample;
            r_record_start <= i_record_start;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_filtered <= w_filtered;
            r_clipped  <= w_clipped;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_filtered;
    assign o_clipped  = r_clipped;

    // Checks
    `SOIIR_ASSERT(a_clip_at_rail, i_clk, i_rst_n, (r_out_valid && r_clipped) |-> ((r_filtered == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) || (r_filtered == {1'b1, {(SAMPLE_BITS-1){1'b0}}})), "clipped result is not at a rail")
    `SOIIR_ASSERT(a_stage_kept, i_clk, i_rst_n, (r_in_valid && !w_step) |=> r_in_valid, "held input item lost")
    `SOIIR_ASSERT(a_step_lands, i_clk, i_rst_n, w_step |=> r_out_valid, "stepped item missing from result register")
    `SOIIR_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_in_valid && !w_step) |-> !w_in_fire, "input register overwritten")
    `SOIIR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_out_valid && !r_in_valid), "registers not empty after reset")

endmodule
